>>> src/ppsh_pkg.sv
// Shared types, constants and helper functions of the parallel printer strobe handshake unit.
package ppsh_pkg;

  localparam int COUNT_WIDTH = 24;
  localparam int LIMIT_WIDTH = 24;
  localparam int WAIT_WIDTH  = 16;
  localparam int CFG_WIDTH   = 24;
  localparam int CMP_WIDTH   = ((COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH) + 1;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  localparam logic [23:0] LIMIT_RESET = 24'd1000;
  localparam logic [15:0] WAIT_RESET  = 16'd0;

  localparam logic [1:0] REG_POLL_LIMIT  = 2'd0;
  localparam logic [1:0] REG_STROBE_WAIT = 2'd1;
  localparam logic [1:0] REG_ABORT       = 2'd2;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_POLL    = 3'd1;
  localparam logic [2:0] PH_SETUP   = 3'd2;
  localparam logic [2:0] PH_STROBE  = 3'd3;
  localparam logic [2:0] PH_RELEASE = 3'd4;

  localparam logic [2:0] OUT_NONE    = 3'd0;
  localparam logic [2:0] OUT_OK      = 3'd1;
  localparam logic [2:0] OUT_TIMEOUT = 3'd2;
  localparam logic [2:0] OUT_PAPER   = 3'd3;
  localparam logic [2:0] OUT_OFFLINE = 3'd4;
  localparam logic [2:0] OUT_ERROR   = 3'd5;

  localparam int ST_NOT_BUSY  = 7;
  localparam int ST_PAPER_OUT = 5;
  localparam int ST_SELECTED  = 4;
  localparam int ST_NOT_ERROR = 3;

  typedef struct packed {
    logic                   abort_on_fault;
    logic [WAIT_WIDTH-1:0]  strobe_wait;
    logic [LIMIT_WIDTH-1:0] ready_poll_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0] status_lines;
    logic [7:0] data_byte;
    logic       func;
  } item_t;

  typedef struct packed {
    logic       abort_request;
    logic [2:0] outcome;
    logic       idle_out;
    logic       strobe_out;
    logic [7:0] data_lines;
  } result_t;

  function automatic logic [COUNT_WIDTH-1:0] eff_limit(input logic [LIMIT_WIDTH-1:0] lim);
    logic [CMP_WIDTH-1:0] l;
    logic [COUNT_WIDTH-1:0] r;
    l = CMP_WIDTH'(lim);
    if (l == '0) begin
      r = COUNT_WIDTH'(1);
    end else if (l > CMP_WIDTH'(CNT_MAX)) begin
      r = CNT_MAX;
    end else begin
      r = l[COUNT_WIDTH-1:0];
    end
    return r;
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] eff_wait(input logic [WAIT_WIDTH-1:0] w);
    logic [CMP_WIDTH-1:0] x;
    logic [CMP_WIDTH-1:0] top;
    logic [COUNT_WIDTH-1:0] r;
    x   = CMP_WIDTH'(w);
    top = CMP_WIDTH'(CNT_MAX) - CMP_WIDTH'(1);
    if (x > top) begin
      r = top[COUNT_WIDTH-1:0];
    end else begin
      r = x[COUNT_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

>>> src/ppsh_cfg_regs.sv
// Configuration register bank of the parallel printer strobe handshake unit.
module ppsh_cfg_regs
  import ppsh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ready_poll_limit <= LIMIT_RESET;
      cfg.strobe_wait      <= WAIT_RESET;
      cfg.abort_on_fault   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POLL_LIMIT:  cfg.ready_poll_limit <= cfg_data[LIMIT_WIDTH-1:0];
        REG_STROBE_WAIT: cfg.strobe_wait      <= cfg_data[WAIT_WIDTH-1:0];
        REG_ABORT:       cfg.abort_on_fault   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> src/ppsh_step.sv
// Next-state and result logic for one tick of the printer handshake.
module ppsh_step
  import ppsh_pkg::*;
(
  input  item_t                   item,
  input  cfg_t                    cfg,
  input  logic [2:0]              phase,
  input  logic [COUNT_WIDTH-1:0]  tick_counter,
  input  logic [7:0]              held_byte,
  output logic [2:0]              phase_next,
  output logic [COUNT_WIDTH-1:0]  tick_counter_next,
  output logic [7:0]              held_byte_next,
  output result_t                 result
);

  logic [COUNT_WIDTH-1:0] lim_eff;
  logic [COUNT_WIDTH-1:0] wait_eff;
  logic [2:0]             phase_start;
  logic [COUNT_WIDTH-1:0] tick_start;
  logic [COUNT_WIDTH:0]   poll_cnt;
  logic [COUNT_WIDTH-1:0] tick_inc;
  logic                   strobe;
  logic [2:0]             outcome;

  assign lim_eff  = eff_limit(cfg.ready_poll_limit);
  assign wait_eff = eff_wait(cfg.strobe_wait);

  always_comb begin
    if (phase == PH_IDLE && item.func) begin
      phase_start    = PH_POLL;
      tick_start     = '0;
      held_byte_next = item.data_byte;
    end else begin
      phase_start    = phase;
      tick_start     = tick_counter;
      held_byte_next = held_byte;
    end
  end

  assign poll_cnt = {1'b0, tick_start} + (COUNT_WIDTH+1)'(1);
  assign tick_inc = tick_start + COUNT_WIDTH'(1);

  always_comb begin
    phase_next        = phase_start;
    tick_counter_next = tick_start;
    strobe            = 1'b0;
    outcome           = OUT_NONE;
    case (phase_start)
      PH_POLL: begin
        if (poll_cnt >= {1'b0, lim_eff}) begin
          outcome           = OUT_TIMEOUT;
          phase_next        = PH_IDLE;
          tick_counter_next = '0;
        end else if (item.status_lines[ST_NOT_BUSY]) begin
          phase_next        = (wait_eff == '0) ? PH_STROBE : PH_SETUP;
          tick_counter_next = '0;
        end else begin
          tick_counter_next = poll_cnt[COUNT_WIDTH-1:0];
        end
      end
      PH_SETUP: begin
        if (tick_inc >= wait_eff) begin
          phase_next        = PH_STROBE;
          tick_counter_next = '0;
        end else begin
          tick_counter_next = tick_inc;
        end
      end
      PH_STROBE: begin
        strobe = 1'b1;
        if ({1'b0, tick_inc} >= ({1'b0, wait_eff} + (COUNT_WIDTH+1)'(1))) begin
          phase_next        = PH_RELEASE;
          tick_counter_next = '0;
        end else begin
          tick_counter_next = tick_inc;
        end
      end
      PH_RELEASE: begin
        if (item.status_lines[ST_PAPER_OUT]) begin
          outcome = OUT_PAPER;
        end else if (!item.status_lines[ST_SELECTED]) begin
          outcome = OUT_OFFLINE;
        end else if (!item.status_lines[ST_NOT_ERROR]) begin
          outcome = OUT_ERROR;
        end else begin
          outcome = OUT_OK;
        end
        phase_next        = PH_IDLE;
        tick_counter_next = '0;
      end
      default: begin
        phase_next        = PH_IDLE;
        tick_counter_next = '0;
      end
    endcase
  end

  always_comb begin
    result.data_lines    = held_byte_next;
    result.strobe_out    = strobe;
    result.idle_out      = (phase_next == PH_IDLE);
    result.outcome       = outcome;
    result.abort_request = cfg.abort_on_fault &&
                           (outcome == OUT_PAPER || outcome == OUT_OFFLINE ||
                            outcome == OUT_ERROR);
  end

endmodule

>>> src/parallel_printer_strobe_handshake_unit.sv
// Top level of the parallel printer strobe handshake unit: stream ports and pipeline registers.
// An accepted item is registered in the input register, then its result in the result register.
// Throughput: one item per cycle; the input register feeds the step logic and the result
// register, and a full result register only stalls the input when the consumer holds off.
// Reset (rst, synchronous): pipeline empty, phase idle, counter and held byte zero,
// registers back to poll limit 1000, strobe wait 0 and abort disabled.
module parallel_printer_strobe_handshake_unit
  import ppsh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [15:0]          s_axis_tdata,  // data_byte [7:0], status_lines [15:8]
  input  logic                 s_axis_tuser,  // func [0]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [15:0]          m_axis_tdata,  // data_lines [7:0], strobe_out [8],
                                              // idle_out [9], outcome [12:10],
                                              // abort_request [13], zero [15:14]
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_data
);

  cfg_t                   cfg;
  logic                   in_valid;
  item_t                  in_item;
  logic                   out_valid;
  result_t                out_result;
  logic                   adv;
  logic [2:0]             phase;
  logic [2:0]             phase_next;
  logic [COUNT_WIDTH-1:0] tick_counter;
  logic [COUNT_WIDTH-1:0] tick_counter_next;
  logic [7:0]             held_byte;
  logic [7:0]             held_byte_next;
  result_t                result_next;

  ppsh_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ppsh_step u_step (
    .item              (in_item),
    .cfg               (cfg),
    .phase             (phase),
    .tick_counter      (tick_counter),
    .held_byte         (held_byte),
    .phase_next        (phase_next),
    .tick_counter_next (tick_counter_next),
    .held_byte_next    (held_byte_next),
    .result            (result_next)
  );

  assign adv           = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || adv;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_result};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (adv) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.func         <= s_axis_tuser;
      in_item.data_byte    <= s_axis_tdata[7:0];
      in_item.status_lines <= s_axis_tdata[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      phase        <= PH_IDLE;
      tick_counter <= '0;
      held_byte    <= '0;
    end else if (adv) begin
      out_valid    <= 1'b1;
      phase        <= phase_next;
      tick_counter <= tick_counter_next;
      held_byte    <= held_byte_next;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_result <= result_next;
    end
  end

`ifndef ASSERT_OFF
  a_release_returns_idle: assert property (@(posedge clk) disable iff (rst)
    adv && phase == PH_RELEASE |=> phase == PH_IDLE)
    else $error("release tick did not return the handshake to idle");

  a_outcome_ends_send: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_result.outcome != OUT_NONE |-> out_result.idle_out && !out_result.strobe_out)
    else $error("outcome reported while a send is still running");

  a_abort_needs_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_result.abort_request |-> cfg.abort_on_fault &&
      (out_result.outcome == OUT_PAPER || out_result.outcome == OUT_OFFLINE ||
       out_result.outcome == OUT_ERROR))
    else $error("abort request without an enabled fault outcome");

  a_state_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(phase) && $stable(tick_counter) && $stable(held_byte))
    else $error("handshake state changed without an item being processed");
`endif

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench of the parallel printer strobe handshake unit with a tick-level predictor.
module tb_top;
  import ppsh_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 6;
  localparam int PIPE_CYCLES  = 6;
  localparam int LONG_STALL   = 300;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam logic [1:0] REG_SPARE = 2'd3;

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata;  // data_byte [7:0], status_lines [15:8]
  logic                 s_axis_tuser;  // func [0]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [15:0]          m_axis_tdata;  // data_lines [7:0], strobe_out [8], idle_out [9],
                                       // outcome [12:10], abort_request [13], zero [15:14]
  logic                 cfg_we;
  logic [1:0]           cfg_index;
  logic [CFG_WIDTH-1:0] cfg_data;

  logic [23:0]            poll_limit;
  logic [15:0]            setup_wait;
  logic                   abort_en;
  logic [2:0]             phase;
  logic [COUNT_WIDTH-1:0] ticks;
  logic [7:0]             held_byte;

  result_t pending_results[$];
  int      mismatches;
  int      send_idle_pct;
  int      recv_idle_pct;
  int      stall_requests;

  parallel_printer_strobe_handshake_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Advances the handshake by one tick and returns the result that tick should produce.
  function automatic result_t step_handshake(input logic start, input logic [7:0] byt,
                                             input logic [7:0] st);
    result_t                r;
    logic [COUNT_WIDTH:0]   next_cnt;
    logic [COUNT_WIDTH-1:0] lim;
    r   = '0;
    lim = (poll_limit == '0) ? COUNT_WIDTH'(1) : COUNT_WIDTH'(poll_limit);
    if (phase == PH_IDLE && start) begin
      held_byte = byt;
      phase     = PH_POLL;
      ticks     = '0;
    end
    case (phase)
      PH_POLL: begin
        next_cnt = {1'b0, ticks} + 1'b1;
        if (next_cnt >= {1'b0, lim}) begin
          r.outcome = OUT_TIMEOUT;
          phase     = PH_IDLE;
          ticks     = '0;
        end else if (st[ST_NOT_BUSY]) begin
          phase = (setup_wait == '0) ? PH_STROBE : PH_SETUP;
          ticks = '0;
        end else begin
          ticks = next_cnt[COUNT_WIDTH-1:0];
        end
      end
      PH_SETUP: begin
        ticks = ticks + 1'b1;
        if (ticks >= COUNT_WIDTH'(setup_wait)) begin
          phase = PH_STROBE;
          ticks = '0;
        end
      end
      PH_STROBE: begin
        r.strobe_out = 1'b1;
        ticks        = ticks + 1'b1;
        if ({1'b0, ticks} >= (COUNT_WIDTH+1)'(setup_wait) + 1'b1) begin
          phase = PH_RELEASE;
          ticks = '0;
        end
      end
      PH_RELEASE: begin
        if (st[ST_PAPER_OUT]) begin
          r.outcome = OUT_PAPER;
        end else if (!st[ST_SELECTED]) begin
          r.outcome = OUT_OFFLINE;
        end else if (!st[ST_NOT_ERROR]) begin
          r.outcome = OUT_ERROR;
        end else begin
          r.outcome = OUT_OK;
        end
        r.abort_request = abort_en && (r.outcome != OUT_OK);
        phase           = PH_IDLE;
        ticks           = '0;
      end
      default: begin
        phase = PH_IDLE;
        ticks = '0;
      end
    endcase
    r.data_lines = held_byte;
    r.idle_out   = (phase == PH_IDLE);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
    mismatches++;
  endtask

  task automatic send_tick(input logic start, input logic [7:0] byt, input logic [7:0] st);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {st, byt};
    s_axis_tuser  <= start;
    do begin
      @(posedge clk);
    end while (!s_axis_tready);
    pending_results.push_back(step_handshake(start, byt, st));
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_WIDTH-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_POLL_LIMIT:  poll_limit = value[23:0];
      REG_STROBE_WAIT: setup_wait = value[15:0];
      REG_ABORT:       abort_en   = value[0];
      default: ;
    endcase
  endtask

  task automatic set_registers(input logic [23:0] lim_v, input logic [15:0] wait_v,
                               input logic abort_v);
    logic [7:0]  wait_upper;
    logic [22:0] abort_upper;
    wait_upper  = 8'($urandom);
    abort_upper = 23'($urandom);
    wait_for_results();
    write_reg(REG_SPARE, CFG_WIDTH'($urandom));
    write_reg(REG_POLL_LIMIT, lim_v);
    write_reg(REG_STROBE_WAIT, {wait_upper, wait_v});
    write_reg(REG_ABORT, {abort_upper, abort_v});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [23:0] pick_poll_limit();
    case ($urandom_range(7))
      0:       return 24'd0;
      1:       return 24'd1;
      2:       return 24'hFFFFFF;
      default: return 24'($urandom_range(12, 2));
    endcase
  endfunction

  function automatic logic [15:0] pick_strobe_wait();
    case ($urandom_range(5))
      0:       return 16'd0;
      1:       return 16'($urandom_range(20, 5));
      default: return 16'($urandom_range(4, 1));
    endcase
  endfunction

  // Mostly ticks that push a send through its phases, the rest plain noise.
  task automatic send_random_tick();
    logic       start;
    logic [7:0] byt;
    logic [7:0] st;
    start = 1'($urandom_range(1));
    byt   = 8'($urandom);
    st    = 8'($urandom);
    if ($urandom_range(9) != 0) begin
      case (phase)
        PH_IDLE: start = ($urandom_range(4) != 0);
        PH_POLL: st[ST_NOT_BUSY] = ($urandom_range(99) < 35);
        PH_RELEASE: begin
          case ($urandom_range(3))
            0: st[ST_PAPER_OUT] = 1'b1;
            1: begin
              st[ST_PAPER_OUT] = 1'b0;
              st[ST_SELECTED]  = 1'b0;
            end
            2: begin
              st[ST_PAPER_OUT] = 1'b0;
              st[ST_SELECTED]  = 1'b1;
              st[ST_NOT_ERROR] = 1'b0;
            end
            default: begin
              st[ST_PAPER_OUT] = 1'b0;
              st[ST_SELECTED]  = 1'b1;
              st[ST_NOT_ERROR] = 1'b1;
            end
          endcase
        end
        default: ;
      endcase
    end
    send_tick(start, byt, st);
  endtask

  task automatic test_default_registers();
    send_idle_pct = 14;
    recv_idle_pct = 78;
    send_tick(1'b0, 8'h00, 8'h00);
    send_tick(1'b1, 8'hA5, 8'h80);
    send_tick(1'b0, 8'hFF, 8'hFF);
    send_tick(1'b0, 8'h00, 8'h98);
  endtask

  task automatic test_start_while_busy();
    set_registers(24'd5, 16'd1, 1'b1);
    send_tick(1'b1, 8'h5A, 8'h00);
    send_tick(1'b1, 8'hC3, 8'h7F);
    send_tick(1'b0, 8'h11, 8'h80);
    send_tick(1'b1, 8'h22, 8'h00);
    send_tick(1'b1, 8'h33, 8'h00);
    send_tick(1'b1, 8'h44, 8'h00);
    send_tick(1'b0, 8'h55, 8'h20);
  endtask

  task automatic test_poll_timeout();
    set_registers(24'd0, 16'd0, 1'b1);
    send_tick(1'b1, 8'hFF, 8'h80);
    set_registers(24'd3, 16'd0, 1'b0);
    send_tick(1'b1, 8'h01, 8'h00);
    send_tick(1'b0, 8'h02, 8'h00);
    send_tick(1'b0, 8'h03, 8'h80);
  endtask

  task automatic test_fault_classes();
    set_registers(24'd4, 16'd0, 1'b1);
    send_tick(1'b1, 8'h81, 8'h80);
    send_tick(1'b0, 8'h00, 8'h00);
    send_tick(1'b0, 8'h00, 8'h00);
    send_tick(1'b1, 8'h42, 8'h80);
    send_tick(1'b0, 8'h00, 8'h00);
    send_tick(1'b0, 8'h00, 8'h10);
    send_tick(1'b1, 8'h24, 8'hFF);
    send_tick(1'b0, 8'h00, 8'h00);
    send_tick(1'b0, 8'h00, 8'hFF);
  endtask

  task automatic test_random_traffic(input int items, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int n = 0; n < items; n++) begin
      if (n % 100 == 0)
        set_registers(pick_poll_limit(), pick_strobe_wait(), 1'($urandom_range(1)));
      send_random_tick();
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_registers(24'd6, 16'd2, 1'b1);
    stall_requests++;
    repeat (150) send_random_tick();
    wait_for_results();
  endtask

  task automatic test_longest_strobe();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_registers(24'hFFFFFF, 16'd60, 1'b0);
    send_tick(1'b1, 8'h3C, 8'h80);
    while (phase != PH_IDLE) send_tick(1'b0, 8'($urandom), 8'($urandom));
  endtask

  initial begin : receiver
    int seen;
    seen = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_requests != seen) begin
        seen = stall_requests;
        m_axis_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[13:0];
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", int'(m_axis_tdata), 0);
      end else begin
        want = pending_results.pop_front();
        if (got.data_lines != want.data_lines)
          report_mismatch("data_lines", int'(got.data_lines), int'(want.data_lines));
        if (got.strobe_out != want.strobe_out)
          report_mismatch("strobe_out", int'(got.strobe_out), int'(want.strobe_out));
        if (got.idle_out != want.idle_out)
          report_mismatch("idle_out", int'(got.idle_out), int'(want.idle_out));
        if (got.outcome != want.outcome)
          report_mismatch("outcome", int'(got.outcome), int'(want.outcome));
        if (got.abort_request != want.abort_request)
          report_mismatch("abort_request", int'(got.abort_request),
                          int'(want.abort_request));
        if (m_axis_tdata[15:14] != 2'b00)
          report_mismatch("padding", int'(m_axis_tdata[15:14]), 0);
      end
    end
  end

  initial begin : watchdog
    for (int c = 0; c < CYCLE_LIMIT; c++) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst            <= 1'b1;
    s_axis_tvalid  <= 1'b0;
    s_axis_tdata   <= '0;
    s_axis_tuser   <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    poll_limit     = LIMIT_RESET;
    setup_wait     = WAIT_RESET;
    abort_en       = 1'b0;
    phase          = PH_IDLE;
    ticks          = '0;
    held_byte      = '0;
    mismatches     = 0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    stall_requests = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_registers();
    test_start_while_busy();
    test_poll_timeout();
    test_fault_classes();
    test_random_traffic(400, 14, 78);
    test_random_traffic(400, 78, 14);
    test_backpressure();
    test_random_traffic(400, 0, 0);
    test_longest_strobe();

    wait_for_results();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> parallel_printer_strobe_handshake_unit.f
src/ppsh_pkg.sv
src/ppsh_cfg_regs.sv
src/ppsh_step.sv
src/parallel_printer_strobe_handshake_unit.sv
tb/sv/tb_top.sv
